[hdl/pewin_pkg.sv]
// Shared types and constants of the paged EEPROM and RAM window.
// Used by the top level paged_eeprom_and_ram_window_core and by its bench.
package pewin_pkg;

   // Default sizes; all three must be powers of two.
   localparam int EEPROM_BYTES_DEF = 2048;
   localparam int RAM_BYTES_DEF    = 2048;
   localparam int PAGE_BYTES_DEF   = 128;

   // Control register bits and nibble codes.
   localparam logic [7:0] CTL_BUSY    = 8'h01;
   localparam logic [7:0] CTL_ENABLE  = 8'h02;
   localparam logic [7:0] NIBBLE_MASK = 8'hf0;
   localparam logic [7:0] NIBBLE_ARM  = 8'h50;
   localparam logic [7:0] NIBBLE_FIRE = 8'ha0;

   localparam logic [7:0] ERASED_BYTE = 8'hff;

   typedef enum logic [1:0] {
      CMD_DATA_RD = 2'd0,
      CMD_DATA_WR = 2'd1,
      CMD_CTL_RD  = 2'd2,
      CMD_CTL_WR  = 2'd3
   } cmd_type;

   // Where the read byte of a response comes from.
   typedef enum logic [1:0] {
      SRC_ZERO   = 2'd0,
      SRC_CTL    = 2'd1,
      SRC_EEPROM = 2'd2,
      SRC_RAM    = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_RUN    = 2'd1,
      ST_COMMIT = 2'd2
   } state_type;

endpackage

[hdl/pewin_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the EEPROM store, the RAM store and the column latch; no package needed.
module pewin_ram #(
   parameter int  DEPTH = 256,
   parameter int  WIDTH = 8,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/paged_eeprom_and_ram_window_core.sv]
// Paged EEPROM and RAM window: top level with control register, latch control and commit.
// Depends on pewin_pkg and instantiates pewin_ram three times.
//
// The block takes one request per cycle when ready and answers every request with exactly
// one response, registered through the middle stage and the output register; a stalled
// response is held in an output register while one more request is taken. After reset
// the block sweeps both stores to their erased values and accepts no request until the
// sweep has covered max(EEPROM_BYTES, RAM_BYTES) addresses. A control write that fires a
// page commit stalls requests while the commit sequencer walks the column latch, one entry
// a cycle through its single read port into the EEPROM write port, and until the write of
// a marked last entry is done. All three sizes must be powers of two.
module paged_eeprom_and_ram_window_core #(
   parameter int EEPROM_BYTES = pewin_pkg::EEPROM_BYTES_DEF,
   parameter int RAM_BYTES    = pewin_pkg::RAM_BYTES_DEF,
   parameter int PAGE_BYTES   = pewin_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] write_data
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] page_cross_error,
                                    // [9] out_of_range, [15:10] zero
);

   localparam int EA   = $clog2(EEPROM_BYTES);
   localparam int RA   = $clog2(RAM_BYTES);
   localparam int PA   = $clog2(PAGE_BYTES);
   localparam int PGW  = (EA > PA) ? EA - PA : 1;
   localparam int MAXB = (EEPROM_BYTES > RAM_BYTES) ? EEPROM_BYTES : RAM_BYTES;
   localparam int CW   = $clog2(MAXB);

   // Request fields.
   pewin_pkg::cmd_type req_cmd;
   logic [15:0]        req_address;
   logic [7:0]         req_write_data;

   assign req_cmd        = pewin_pkg::cmd_type'(req_tuser);
   assign req_address    = req_tdata[15:0];
   assign req_write_data = req_tdata[23:16];

   // Control state.
   pewin_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        clr_idx_ff;
   logic [PA-1:0]        cm_idx_ff;
   logic                 cw_pend_ff;
   logic [PA-1:0]        cw_idx_ff;
   logic [7:0]           ctl_ff;
   logic [PGW-1:0]       page_base_ff;
   logic                 base_valid_ff;
   logic [PAGE_BYTES-1:0] latch_valid_ff;

   // Middle stage and output register.
   logic                 s1_valid_ff;
   pewin_pkg::src_type   s1_src_ff;
   logic [7:0]           s1_ctl_ff;
   logic                 s1_perr_ff;
   logic                 s1_oor_ff;
   logic                 out_valid_ff;
   logic [7:0]           out_data_ff;
   logic                 out_perr_ff;
   logic                 out_oor_ff;

   // Decode.
   logic                 accept;
   logic                 s1_move;
   logic                 ee_mode;
   logic                 ee_in_range;
   logic                 ram_in_range;
   logic [PGW-1:0]       page_num;
   logic [PA-1:0]        page_off;
   logic                 commit_hit;
   logic                 clr_last;
   logic                 cm_last;
   logic                 latch_wr;
   logic                 page_cross;
   logic                 ee_we, ee_re, ram_we, ram_re, latch_re;
   logic [EA-1:0]        ee_waddr;
   logic [7:0]           ee_wdata, ee_rdata, ram_wdata, ram_rdata, latch_rdata;
   logic [RA-1:0]        ram_waddr;
   pewin_pkg::src_type   src;
   logic [7:0]           s1_data;

   assign ee_mode      = (ctl_ff & pewin_pkg::CTL_ENABLE) != 8'h00;
   assign ee_in_range  = 32'(req_address) < EEPROM_BYTES;
   assign ram_in_range = 32'(req_address) < RAM_BYTES;
   assign page_num     = PGW'(32'(req_address) >> PA);
   assign page_off     = req_address[PA-1:0];
   assign commit_hit   = ((req_write_data & pewin_pkg::NIBBLE_MASK) == pewin_pkg::NIBBLE_FIRE)
                         && ((ctl_ff & pewin_pkg::NIBBLE_MASK) == pewin_pkg::NIBBLE_ARM);
   assign clr_last     = 32'(clr_idx_ff) == MAXB - 1;
   assign cm_last      = 32'(cm_idx_ff) == PAGE_BYTES - 1;
   assign s1_move      = !out_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pewin_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = pewin_pkg::ST_RUN;
            end
         end
         pewin_pkg::ST_RUN: begin
            if (accept && req_cmd == pewin_pkg::CMD_CTL_WR && commit_hit) begin
               state_in = pewin_pkg::ST_COMMIT;
            end
         end
         pewin_pkg::ST_COMMIT: begin
            if (cm_last) begin
               state_in = pewin_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = pewin_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs of the state machine: ready, memory ports and response source.
   always_comb begin
      req_tready = (state_ff == pewin_pkg::ST_RUN) && !cw_pend_ff
                   && (!s1_valid_ff || s1_move);
      ee_re      = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      latch_wr   = 1'b0;
      page_cross = 1'b0;
      src        = pewin_pkg::SRC_ZERO;
      latch_re   = state_ff == pewin_pkg::ST_COMMIT;
      if (state_ff == pewin_pkg::ST_CLEAR) begin
         ee_we     = 32'(clr_idx_ff) < EEPROM_BYTES;
         ee_waddr  = EA'(clr_idx_ff);
         ee_wdata  = pewin_pkg::ERASED_BYTE;
         ram_we    = 32'(clr_idx_ff) < RAM_BYTES;
         ram_waddr = RA'(clr_idx_ff);
         ram_wdata = 8'h00;
      end else begin
         ee_we     = cw_pend_ff;
         ee_waddr  = EA'((32'(page_base_ff) << PA) | 32'(cw_idx_ff));
         ee_wdata  = latch_rdata;
         ram_waddr = req_address[RA-1:0];
         ram_wdata = req_write_data;
         case (req_cmd)
            pewin_pkg::CMD_DATA_RD: begin
               if (ee_mode && ee_in_range) begin
                  ee_re = accept;
                  src   = pewin_pkg::SRC_EEPROM;
               end else if (!ee_mode && ram_in_range) begin
                  ram_re = accept;
                  src    = pewin_pkg::SRC_RAM;
               end
            end
            pewin_pkg::CMD_DATA_WR: begin
               if (ee_mode && ee_in_range) begin
                  latch_wr   = accept;
                  page_cross = base_valid_ff && (page_base_ff != page_num);
               end else if (!ee_mode && ram_in_range) begin
                  ram_we = accept;
               end
            end
            pewin_pkg::CMD_CTL_RD: begin
               src = pewin_pkg::SRC_CTL;
            end
            default: begin
               src = pewin_pkg::SRC_ZERO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pewin_pkg::ST_CLEAR;
         clr_idx_ff     <= '0;
         cm_idx_ff      <= '0;
         cw_pend_ff     <= 1'b0;
         ctl_ff         <= 8'h00;
         page_base_ff   <= '0;
         base_valid_ff  <= 1'b0;
         latch_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cw_pend_ff <= (state_ff == pewin_pkg::ST_COMMIT) && latch_valid_ff[cm_idx_ff];
         if (state_ff == pewin_pkg::ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         // Commit sequencer: read one latch entry a cycle, write it, if marked, to the EEPROM next cycle.
         if (state_ff == pewin_pkg::ST_COMMIT) begin
            cm_idx_ff                 <= cm_idx_ff + 1'b1;
            latch_valid_ff[cm_idx_ff] <= 1'b0;
         end
         if (accept && req_cmd == pewin_pkg::CMD_CTL_WR) begin
            ctl_ff <= req_write_data & ~pewin_pkg::CTL_BUSY;
            if (commit_hit) begin
               cm_idx_ff     <= '0;
               base_valid_ff <= 1'b0;
            end
         end
         if (latch_wr) begin
            page_base_ff             <= page_num;
            base_valid_ff            <= 1'b1;
            latch_valid_ff[page_off] <= 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pewin_pkg::ST_COMMIT) begin
         cw_idx_ff <= cm_idx_ff;
      end
      if (accept) begin
         s1_src_ff  <= src;
         s1_ctl_ff  <= ctl_ff;
         s1_perr_ff <= page_cross;
         s1_oor_ff  <= (req_cmd == pewin_pkg::CMD_DATA_RD || req_cmd == pewin_pkg::CMD_DATA_WR)
                       && (ee_mode ? !ee_in_range : !ram_in_range);
      end
      if (s1_move && s1_valid_ff) begin
         out_data_ff <= s1_data;
         out_perr_ff <= s1_perr_ff;
         out_oor_ff  <= s1_oor_ff;
      end
   end

   always_comb begin
      case (s1_src_ff)
         pewin_pkg::SRC_CTL:    s1_data = s1_ctl_ff;
         pewin_pkg::SRC_EEPROM: s1_data = ee_rdata;
         pewin_pkg::SRC_RAM:    s1_data = ram_rdata;
         default:               s1_data = 8'h00;
      endcase
   end

   pewin_ram #(.DEPTH(EEPROM_BYTES), .WIDTH(8)) u_eeprom (
      .clock   (clock),
      .wr_en   (ee_we),
      .wr_addr (ee_waddr),
      .wr_data (ee_wdata),
      .rd_en   (ee_re),
      .rd_addr (req_address[EA-1:0]),
      .rd_data (ee_rdata)
   );

   pewin_ram #(.DEPTH(RAM_BYTES), .WIDTH(8)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (req_address[RA-1:0]),
      .rd_data (ram_rdata)
   );

   pewin_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_latch (
      .clock   (clock),
      .wr_en   (latch_wr),
      .wr_addr (page_off),
      .wr_data (req_write_data),
      .rd_en   (latch_re),
      .rd_addr (cm_idx_ff),
      .rd_data (latch_rdata)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_oor_ff, out_perr_ff, out_data_ff};

`ifndef SYNTH
   // Once the commit walk has finished, no latch entry is still marked.
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pewin_pkg::ST_COMMIT && state_in == pewin_pkg::ST_RUN)
      |=> (latch_valid_ff == '0 && !base_valid_ff))
      else $error("latch marks left after page commit");

   // The busy bit never holds a one.
   a_busy_zero: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff & pewin_pkg::CTL_BUSY) == 8'h00)
      else $error("busy bit set in control register");

   // A pending commit write to the EEPROM never overlaps an accepted request.
   a_commit_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pewin_pkg::ST_RUN && ee_we) |-> !accept)
      else $error("request accepted during commit drain");
`endif

endmodule

[bench/tb_paged_eeprom_and_ram_window_core.sv]
// Self-checking bench for paged_eeprom_and_ram_window_core: directed and random bus requests.
// Depends on pewin_pkg and the core; holds its own model of the control register and both stores.
module tb_paged_eeprom_and_ram_window_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pewin_pkg::*;

   localparam int EE_BYTES   = EEPROM_BYTES_DEF;
   localparam int RAM_SIZE   = RAM_BYTES_DEF;
   localparam int PAGE_SIZE  = PAGE_BYTES_DEF;
   localparam int RANDOM_REQUESTS = 1025;
   localparam int STALL_LIMIT     = 10000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] address;
      logic [7:0]  write_data;
   } access_t;

   typedef struct packed {
      logic [7:0] read_data;
      logic       page_cross_error;
      logic       out_of_range;
   } window_rsp_t;

   typedef struct packed {
      access_t     acc;
      logic        typed;
      window_rsp_t rsp;
   } directed_row_t;

   localparam int DIRECTED_ROWS = 29;
   localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
      // RAM after reset, its edges and beyond
      '{'{CMD_DATA_RD, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h07ff, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h0800, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{CMD_CTL_RD,  16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_WR, 16'h0000, 8'hff}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_WR, 16'h07ff, 8'h5a}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_WR, 16'hffff, 8'hff}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{CMD_DATA_RD, 16'h0000, 8'h00}, 1'b0, '0},
      '{'{CMD_DATA_RD, 16'h07ff, 8'h00}, 1'b0, '0},
      '{'{CMD_DATA_RD, 16'hffff, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      // Select the EEPROM with the busy bit set; it must read back clear.
      '{'{CMD_CTL_WR,  16'h0000, 8'h03}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_CTL_RD,  16'h0000, 8'h00}, 1'b1, '{8'h02, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h0000, 8'h00}, 1'b1, '{8'hff, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h07ff, 8'h00}, 1'b1, '{8'hff, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h0800, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{CMD_DATA_WR, 16'h0005, 8'ha5}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_WR, 16'h007f, 8'h3c}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      // Crossing into page one: old offsets are carried to the new page.
      '{'{CMD_DATA_WR, 16'h0080, 8'hc3}, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{'{CMD_DATA_WR, 16'hffff, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{CMD_CTL_WR,  16'h0000, 8'h53}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_CTL_WR,  16'h0000, 8'ha2}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_DATA_RD, 16'h0085, 8'h00}, 1'b0, '0},
      '{'{CMD_DATA_RD, 16'h00ff, 8'h00}, 1'b0, '0},
      '{'{CMD_DATA_RD, 16'h0005, 8'h00}, 1'b0, '0},
      // Arm and fire with nothing latched, then write all ones, which neither arms nor fires.
      '{'{CMD_CTL_WR,  16'h0000, 8'h52}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_CTL_WR,  16'h0000, 8'ha2}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_CTL_WR,  16'h0000, 8'hff}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{CMD_CTL_RD,  16'h0000, 8'h00}, 1'b1, '{8'hfe, 1'b0, 1'b0}},
      '{'{CMD_CTL_WR,  16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // [15:0] address, [23:16] write_data
   logic [1:0]  req_tuser;    // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] read_data, [8] page_cross_error, [9] out_of_range

   paged_eeprom_and_ram_window_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the window's state, advanced once per accepted request.
   logic [7:0]  ctl_shadow;
   logic [7:0]  eeprom_shadow [EE_BYTES];
   logic [7:0]  ram_shadow [RAM_SIZE];
   logic [7:0]  latch_bytes [PAGE_SIZE];
   bit          latch_marks [PAGE_SIZE];
   int unsigned page_base_shadow;
   bit          page_base_valid;

   window_rsp_t awaited_responses [$];
   int unsigned failures;
   int unsigned requests_accepted;
   int unsigned responses_checked;
   int unsigned page_commits;
   int unsigned page_crossings;
   int unsigned range_misses;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic window_rsp_t predict_access(input access_t acc);
      window_rsp_t rsp;
      bit          ee_mode;
      int unsigned limit;
      int unsigned pg;
      int unsigned off;
      int unsigned dst;
      rsp = '0;
      ee_mode = (ctl_shadow & CTL_ENABLE) != 8'h00;
      limit = ee_mode ? EE_BYTES : RAM_SIZE;
      pg = acc.address / PAGE_SIZE;
      off = acc.address % PAGE_SIZE;
      case (acc.cmd)
         CMD_DATA_RD: begin
            if (acc.address >= limit)
               rsp.out_of_range = 1'b1;
            else
               rsp.read_data = ee_mode ? eeprom_shadow[acc.address] : ram_shadow[acc.address];
         end
         CMD_DATA_WR: begin
            if (acc.address >= limit) begin
               rsp.out_of_range = 1'b1;
            end else if (ee_mode) begin
               if (page_base_valid && page_base_shadow != pg) begin
                  rsp.page_cross_error = 1'b1;
                  page_crossings++;
               end
               page_base_shadow = pg;
               page_base_valid = 1'b1;
               latch_bytes[off] = acc.write_data;
               latch_marks[off] = 1'b1;
            end else begin
               ram_shadow[acc.address] = acc.write_data;
            end
         end
         CMD_CTL_RD: rsp.read_data = ctl_shadow;
         default: begin
            if ((acc.write_data & NIBBLE_MASK) == NIBBLE_FIRE &&
                (ctl_shadow & NIBBLE_MASK) == NIBBLE_ARM) begin
               for (int i = 0; i < PAGE_SIZE; i++) begin
                  if (latch_marks[i]) begin
                     dst = page_base_shadow * PAGE_SIZE + i;
                     latch_marks[i] = 1'b0;
                     if (dst < EE_BYTES)
                        eeprom_shadow[dst] = latch_bytes[i];
                  end
               end
               page_base_valid = 1'b0;
               page_commits++;
            end
            ctl_shadow = acc.write_data & ~CTL_BUSY;
         end
      endcase
      if (rsp.out_of_range)
         range_misses++;
      return rsp;
   endfunction

   // Mostly addresses inside the memories, with a bias to the latched page so that
   // commits land on bytes that are later read back.
   function automatic logic [15:0] pick_address();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 8)
         return 16'($urandom_range(0, 65535));
      if (k < 50 && page_base_valid)
         return 16'(page_base_shadow * PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1));
      if (k < 56)
         return 16'(EE_BYTES - 1 + $urandom_range(0, 1));
      return 16'($urandom_range(0, EE_BYTES - 1));
   endfunction

   function automatic access_t random_access();
      access_t     acc;
      int unsigned k;
      logic [3:0]  high_nibble;
      logic [3:0]  low_nibble;
      k = $urandom_range(0, 99);
      acc.write_data = 8'($urandom_range(0, 255));
      acc.address = pick_address();
      if (k < 30) begin
         acc.cmd = CMD_DATA_RD;
      end else if (k < 62) begin
         acc.cmd = CMD_DATA_WR;
      end else if (k < 70) begin
         acc.cmd = CMD_CTL_RD;
      end else begin
         // Control writes mostly keep the EEPROM selected and follow an arm with a fire.
         acc.cmd = CMD_CTL_WR;
         low_nibble = 4'($urandom_range(0, 15));
         low_nibble[1] = $urandom_range(0, 99) < 70;
         if ((ctl_shadow & NIBBLE_MASK) == NIBBLE_ARM && $urandom_range(0, 9) < 7)
            high_nibble = NIBBLE_FIRE[7:4];
         else if ($urandom_range(0, 9) < 4)
            high_nibble = NIBBLE_ARM[7:4];
         else
            high_nibble = 4'($urandom_range(0, 15));
         acc.write_data = {high_nibble, low_nibble};
      end
      return acc;
   endfunction

   // Every so often a stretch of back-to-back traffic, otherwise random gaps.
   function automatic int unsigned draw_wait(input int unsigned idx);
      if (idx % 200 < 40)
         return 0;
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic issue_request(input access_t acc, input bit typed, input window_rsp_t typed_rsp,
                                input int unsigned wait_cycles);
      window_rsp_t predicted;
      if (wait_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {acc.write_data, acc.address};
      req_tuser <= acc.cmd;
      do @(posedge clock); while (!req_tready);
      predicted = predict_access(acc);
      awaited_responses.push_back(typed ? typed_rsp : predicted);
      requests_accepted++;
   endtask

   // Response side: random back-pressure, one long hold-off, and the field checks.
   initial begin
      window_rsp_t want;
      window_rsp_t got;
      int unsigned wait_cycles;
      bit          held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (responses_checked == 400 && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         wait_cycles = draw_wait(responses_checked + 100);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = {rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9]};
         responses_checked++;
         if (awaited_responses.size() == 0) begin
            $error("unexpected response %h with nothing outstanding", rsp_tdata);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, got.read_data);
               failures++;
            end
            if (got.page_cross_error !== want.page_cross_error) begin
               $error("page_cross_error: expected %b, got %b",
                      want.page_cross_error, got.page_cross_error);
               failures++;
            end
            if (got.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %b, got %b", want.out_of_range, got.out_of_range);
               failures++;
            end
         end
      end
   end

   // Watchdog: the clearing sweep after reset is the longest legitimate quiet spell.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d responses outstanding", awaited_responses.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      failures = 0;
      requests_accepted = 0;
      responses_checked = 0;
      page_commits = 0;
      page_crossings = 0;
      range_misses = 0;
      idle_cycles = 0;
      ctl_shadow = 8'h00;
      page_base_shadow = 0;
      page_base_valid = 1'b0;
      foreach (eeprom_shadow[i]) eeprom_shadow[i] = ERASED_BYTE;
      foreach (ram_shadow[i]) ram_shadow[i] = 8'h00;
      foreach (latch_marks[i]) latch_marks[i] = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_DATA_RD;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         issue_request(DIRECTED[i].acc, DIRECTED[i].typed, DIRECTED[i].rsp, draw_wait(i + 50));
      for (int i = 0; i < RANDOM_REQUESTS; i++)
         issue_request(random_access(), 1'b0, '0, draw_wait(i));
      req_tvalid <= 1'b0;

      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d directed) and %0d responses.",
               requests_accepted, DIRECTED_ROWS, responses_checked);
      $display("It saw %0d page commits, %0d page crossings and %0d out-of-range accesses.",
               page_commits, page_crossings, range_misses);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hdl/pewin_pkg.sv
hdl/pewin_ram.sv
hdl/paged_eeprom_and_ram_window_core.sv
bench/tb_paged_eeprom_and_ram_window_core.sv
